// ===== rtl/atomic_memory_op_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Atomic memory op unit assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ATOMIC_MEMORY_OP_UNIT_ASSERT_SVH
`define ATOMIC_MEMORY_OP_UNIT_ASSERT_SVH

`ifndef SYNTH

`define AMOU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atomic_memory_op_unit: same-cycle check failed");

`define AMOU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atomic_memory_op_unit: next-cycle check failed");

`else

`define AMOU_ASSERT_SAME(label, clk, rst, ante, cons)

`define AMOU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/amou_pkg.sv =====
// ----------------------------------------------------------------------------
// Atomic memory op unit package
// Decode constants, operation codes and the queue entry format.
// ----------------------------------------------------------------------------
`default_nettype none

package amou_pkg;

   localparam logic [31:0] AMO_MASK = 32'hf800707f;
   localparam logic [31:0] LR_MASK  = 32'hf9f0707f;

   localparam logic [6:0] OPC_AMO  = 7'h2f;
   localparam logic [2:0] F3_WORD  = 3'd2;
   localparam logic [2:0] F3_DWORD = 3'd3;

   localparam logic [4:0] F5_ADD  = 5'h00;
   localparam logic [4:0] F5_SWAP = 5'h01;
   localparam logic [4:0] F5_LR   = 5'h02;
   localparam logic [4:0] F5_SC   = 5'h03;
   localparam logic [4:0] F5_XOR  = 5'h04;
   localparam logic [4:0] F5_OR   = 5'h08;
   localparam logic [4:0] F5_AND  = 5'h0c;
   localparam logic [4:0] F5_MIN  = 5'h10;
   localparam logic [4:0] F5_MAX  = 5'h14;
   localparam logic [4:0] F5_MINU = 5'h18;
   localparam logic [4:0] F5_MAXU = 5'h1c;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ADD,
      OP_SWAP,
      OP_XOR,
      OP_OR,
      OP_AND,
      OP_MIN,
      OP_MAX,
      OP_MINU,
      OP_MAXU,
      OP_LR,
      OP_SC
   } amo_op_type;

   typedef struct packed {
      amo_op_type  op;
      logic        word;
      logic        rd_write;
      logic [63:0] addr;
      logic [63:0] mem;
      logic [63:0] opnd;
   } amo_entry_type;

endpackage

`default_nettype wire

// ===== rtl/amou_if.sv =====
// ----------------------------------------------------------------------------
// Atomic memory op unit channels
// Valid/ready request and response channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface amou_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] insn;
   logic [63:0] rs1_value;
   logic [63:0] rs2_value;
   logic [63:0] mem_rdata;

   modport source (output valid, insn, rs1_value, rs2_value, mem_rdata, input ready);
   modport sink   (input valid, insn, rs1_value, rs2_value, mem_rdata, output ready);
endinterface

interface amou_rsp_if;
   logic        valid;
   logic        ready;
   logic        handled;
   logic        mem_write;
   logic [63:0] mem_wdata;
   logic        word_size;
   logic        rd_write;
   logic [63:0] rd_value;

   modport source (output valid, handled, mem_write, mem_wdata, word_size, rd_write,
                   rd_value, input ready);
   modport sink   (input valid, handled, mem_write, mem_wdata, word_size, rd_write,
                   rd_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/amou_front.sv =====
// ----------------------------------------------------------------------------
// Atomic memory op unit front end
// Accepts requests, decodes the instruction and extends the operands.
// ----------------------------------------------------------------------------
`default_nettype none

module amou_front (
   amou_req_if.sink                 req_ch,
   output logic                     push_valid,
   input  logic                     push_ready,
   output amou_pkg::amo_entry_type  push_data
);

   logic [31:0]          insn_amo;
   logic [31:0]          insn_lr;
   logic [4:0]           f5;
   logic [4:0]           rs2f;
   logic [4:0]           rdf;
   logic [2:0]           f3;
   logic                 is_amo;
   logic                 lr_ok;
   logic                 word;
   logic [63:0]          opnd_raw;
   amou_pkg::amo_op_type op;

   assign req_ch.ready = push_ready;
   assign push_valid   = req_ch.valid;

   assign insn_amo = req_ch.insn & amou_pkg::AMO_MASK;
   assign insn_lr  = req_ch.insn & amou_pkg::LR_MASK;
   assign f5       = insn_amo[31:27];
   assign f3       = insn_amo[14:12];
   assign rs2f     = req_ch.insn[24:20];
   assign rdf      = req_ch.insn[11:7];
   assign lr_ok    = (insn_lr == insn_amo);
   assign word     = (f3 == amou_pkg::F3_WORD);
   assign opnd_raw = (rs2f != 5'd0) ? req_ch.rs2_value : 64'd0;

   always_comb begin
      is_amo = (insn_amo[6:0] == amou_pkg::OPC_AMO) &&
               (f3 inside {amou_pkg::F3_WORD, amou_pkg::F3_DWORD});
      op = amou_pkg::OP_NONE;
      if (is_amo) begin
         case (f5)
            amou_pkg::F5_ADD:  op = amou_pkg::OP_ADD;
            amou_pkg::F5_SWAP: op = amou_pkg::OP_SWAP;
            amou_pkg::F5_XOR:  op = amou_pkg::OP_XOR;
            amou_pkg::F5_OR:   op = amou_pkg::OP_OR;
            amou_pkg::F5_AND:  op = amou_pkg::OP_AND;
            amou_pkg::F5_MIN:  op = amou_pkg::OP_MIN;
            amou_pkg::F5_MAX:  op = amou_pkg::OP_MAX;
            amou_pkg::F5_MINU: op = amou_pkg::OP_MINU;
            amou_pkg::F5_MAXU: op = amou_pkg::OP_MAXU;
            amou_pkg::F5_SC:   op = amou_pkg::OP_SC;
            amou_pkg::F5_LR:   op = lr_ok ? amou_pkg::OP_LR : amou_pkg::OP_NONE;
            default:           op = amou_pkg::OP_NONE;
         endcase
      end
   end

   always_comb begin
      push_data.op       = op;
      push_data.word     = (op != amou_pkg::OP_NONE) && word;
      push_data.rd_write = (op != amou_pkg::OP_NONE) && (rdf != 5'd0);
      push_data.addr     = req_ch.rs1_value;
      push_data.mem      = word ? {{32{req_ch.mem_rdata[31]}}, req_ch.mem_rdata[31:0]}
                                : req_ch.mem_rdata;
      push_data.opnd     = word ? {{32{opnd_raw[31]}}, opnd_raw[31:0]} : opnd_raw;
   end

endmodule

`default_nettype wire

// ===== rtl/amou_queue.sv =====
// ----------------------------------------------------------------------------
// Atomic memory op unit decoupling queue
// Small FIFO of decoded requests between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module amou_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  amou_pkg::amo_entry_type  in_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output amou_pkg::amo_entry_type  out_data
);

   amou_pkg::amo_entry_type           entries_ff [amou_pkg::QUEUE_DEPTH];
   logic [amou_pkg::QPTR_W-1:0]       wr_ptr_ff;
   logic [amou_pkg::QPTR_W-1:0]       wr_ptr_in;
   logic [amou_pkg::QPTR_W-1:0]       rd_ptr_ff;
   logic [amou_pkg::QPTR_W-1:0]       rd_ptr_in;
   logic [amou_pkg::QCNT_W-1:0]       count_ff;
   logic [amou_pkg::QCNT_W-1:0]       count_in;
   logic                              push;
   logic                              pop;

   localparam logic [amou_pkg::QPTR_W-1:0] PTR_LAST = amou_pkg::QPTR_W'(amou_pkg::QUEUE_DEPTH - 1);
   localparam logic [amou_pkg::QCNT_W-1:0] CNT_FULL = amou_pkg::QCNT_W'(amou_pkg::QUEUE_DEPTH);

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + amou_pkg::QCNT_W'(push) - amou_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/amou_back.sv =====
// ----------------------------------------------------------------------------
// Atomic memory op unit back end
// Executes decoded requests, keeps the reservation and holds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module amou_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   output logic                     q_ready,
   input  amou_pkg::amo_entry_type  q_data,
   amou_rsp_if.source               rsp_ch
);

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [63:0] reserved_ff;
   logic [63:0] reserved_in;
   logic        handled_ff;
   logic        mem_write_ff;
   logic [63:0] mem_wdata_ff;
   logic        word_size_ff;
   logic        rd_write_ff;
   logic [63:0] rd_value_ff;

   logic        issue;
   logic        sc_ok;
   logic        lt_s;
   logic        lt_u;
   logic [63:0] sum;
   logic        wr;
   logic [63:0] wd;
   logic [63:0] rdv;
   logic        handled_in;
   logic [63:0] mem_wdata_in;
   logic [63:0] rd_value_in;

   assign q_ready = !rsp_valid_ff || rsp_ch.ready;
   assign issue   = q_valid && q_ready;

   assign sc_ok = (reserved_ff == q_data.addr);
   assign lt_s  = $signed(q_data.mem) < $signed(q_data.opnd);
   assign lt_u  = q_data.mem < q_data.opnd;
   assign sum   = q_data.mem + q_data.opnd;

   always_comb begin
      wr  = 1'b0;
      wd  = q_data.opnd;
      rdv = q_data.mem;
      case (q_data.op)
         amou_pkg::OP_ADD: begin
            wr = 1'b1;
            wd = sum;
         end
         amou_pkg::OP_SWAP: begin
            wr = 1'b1;
         end
         amou_pkg::OP_XOR: begin
            wr = 1'b1;
            wd = q_data.mem ^ q_data.opnd;
         end
         amou_pkg::OP_OR: begin
            wr = 1'b1;
            wd = q_data.mem | q_data.opnd;
         end
         amou_pkg::OP_AND: begin
            wr = 1'b1;
            wd = q_data.mem & q_data.opnd;
         end
         amou_pkg::OP_MIN: begin
            wr = 1'b1;
            wd = lt_s ? q_data.mem : q_data.opnd;
         end
         amou_pkg::OP_MAX: begin
            wr = 1'b1;
            wd = lt_s ? q_data.opnd : q_data.mem;
         end
         amou_pkg::OP_MINU: begin
            wr = 1'b1;
            wd = lt_u ? q_data.mem : q_data.opnd;
         end
         amou_pkg::OP_MAXU: begin
            wr = 1'b1;
            wd = lt_u ? q_data.opnd : q_data.mem;
         end
         amou_pkg::OP_SC: begin
            wr  = sc_ok;
            rdv = {63'd0, !sc_ok};
         end
         default: begin
            wr = 1'b0;
         end
      endcase

      handled_in   = (q_data.op != amou_pkg::OP_NONE);
      mem_wdata_in = !wr ? 64'd0 : (q_data.word ? {32'd0, wd[31:0]} : wd);
      rd_value_in  = q_data.rd_write ? rdv : 64'd0;

      rsp_valid_in = issue ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
      reserved_in  = (issue && q_data.op == amou_pkg::OP_LR) ? q_data.addr : reserved_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         reserved_ff  <= 64'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         reserved_ff  <= reserved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         handled_ff   <= handled_in;
         mem_write_ff <= wr;
         mem_wdata_ff <= mem_wdata_in;
         word_size_ff <= q_data.word;
         rd_write_ff  <= q_data.rd_write;
         rd_value_ff  <= rd_value_in;
      end
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.handled   = handled_ff;
   assign rsp_ch.mem_write = mem_write_ff;
   assign rsp_ch.mem_wdata = mem_wdata_ff;
   assign rsp_ch.word_size = word_size_ff;
   assign rsp_ch.rd_write  = rd_write_ff;
   assign rsp_ch.rd_value  = rd_value_ff;

endmodule

`default_nettype wire

// ===== rtl/atomic_memory_op_unit.sv =====
// ----------------------------------------------------------------------------
// Atomic memory op unit (RISC-V A extension AMO, LR and SC)
// Path: accepted requests go through the queue into the back end's response register.
// Throughput: one request per cycle unless the back end's response register is held.
// Reset: synchronous; clears the queue, the response valid and the reservation to zero.
// ----------------------------------------------------------------------------
`default_nettype none

`include "atomic_memory_op_unit_assert.svh"

module atomic_memory_op_unit (
   input  logic         clock,
   input  logic         reset,
   amou_req_if.sink     req_ch,
   amou_rsp_if.source   rsp_ch
);

   logic                    push_valid;
   logic                    push_ready;
   amou_pkg::amo_entry_type push_data;
   logic                    q_valid;
   logic                    q_ready;
   amou_pkg::amo_entry_type q_data;

   amou_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   amou_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   amou_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_data  (q_data),
      .rsp_ch  (rsp_ch)
   );

   `AMOU_ASSERT_NEXT(a_issue_sets_rsp, clock, reset, q_valid && q_ready, rsp_ch.valid)
   `AMOU_ASSERT_NEXT(a_none_not_handled, clock, reset, q_valid && q_ready && q_data.op == amou_pkg::OP_NONE, rsp_ch.valid && !rsp_ch.handled)
   `AMOU_ASSERT_SAME(a_trap_zero, clock, reset, rsp_ch.valid && !rsp_ch.handled, !rsp_ch.mem_write && !rsp_ch.rd_write && !rsp_ch.word_size && rsp_ch.mem_wdata == 64'd0 && rsp_ch.rd_value == 64'd0)
   `AMOU_ASSERT_SAME(a_word_upper_zero, clock, reset, rsp_ch.valid && rsp_ch.word_size, rsp_ch.mem_wdata[63:32] == 32'd0)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Atomic memory op unit testbench
// Drives AMO, LR and SC requests over the request channel with random gaps,
// predicts each response (including the LR/SC reservation) and compares it
// field by field with what comes back on the response channel under random
// back-pressure.
// ----------------------------------------------------------------------------

module tb_top;

   localparam int RANDOM_ITEMS   = 950;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_SPACING  = 230;
   localparam logic [4:0] F5_UNUSED = 5'h05;
   localparam logic [6:0] OPC_OTHER = 7'h33;

   typedef struct packed {
      logic [31:0] insn;
      logic [63:0] rs1_value;
      logic [63:0] rs2_value;
      logic [63:0] mem_rdata;
      logic [7:0]  gap;
      logic        drain;
   } amo_request_type;

   typedef struct packed {
      logic        handled;
      logic        mem_write;
      logic [63:0] mem_wdata;
      logic        word_size;
      logic        rd_write;
      logic [63:0] rd_value;
   } amo_result_type;

   logic clock;
   logic reset;

   amou_req_if req_ch();
   amou_rsp_if rsp_ch();

   atomic_memory_op_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   amo_request_type request_q[$];
   amo_result_type  result_q[$];
   logic [63:0]     reserved_addr;
   int              accepted_cnt;
   int              rsp_cnt;
   int              errors;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 64'h0;
         1: return '1;
         2: return 64'h7fff_ffff_ffff_ffff;
         3: return 64'h8000_0000_0000_0000;
         4: return {$urandom, 32'h7fff_ffff};
         5: return {$urandom, 32'h8000_0000};
         6: return {$urandom, 32'hffff_ffff};
         default: return rand64();
      endcase
   endfunction

   function automatic logic [4:0] pick_reg();
      return ($urandom_range(0, 7) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
   endfunction

   function automatic logic [4:0] pick_amo_op();
      case ($urandom_range(0, 10))
         0: return amou_pkg::F5_ADD;
         1: return amou_pkg::F5_SWAP;
         2: return amou_pkg::F5_XOR;
         3: return amou_pkg::F5_OR;
         4: return amou_pkg::F5_AND;
         5: return amou_pkg::F5_MIN;
         6: return amou_pkg::F5_MAX;
         7: return amou_pkg::F5_MINU;
         8: return amou_pkg::F5_MAXU;
         9: return amou_pkg::F5_LR;
         default: return amou_pkg::F5_SC;
      endcase
   endfunction

   function automatic logic [7:0] pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 8'd0;
      if (r < 93) return 8'($urandom_range(1, 3));
      return 8'($urandom_range(8, 40));
   endfunction

   function automatic logic [31:0] encode_amo(logic [4:0] f5, logic [2:0] f3, logic [4:0] rd,
                                              logic [4:0] rs1, logic [4:0] rs2);
      return {f5, 2'($urandom_range(0, 3)), rs2, rs1, f3, rd, amou_pkg::OPC_AMO};
   endfunction

   task automatic push_request(logic [31:0] insn, logic [63:0] addr, logic [63:0] rs2v,
                               logic [63:0] mdata, logic [7:0] gap, logic drain);
      amo_request_type r;
      r.insn      = insn;
      r.rs1_value = addr;
      r.rs2_value = rs2v;
      r.mem_rdata = mdata;
      r.gap       = gap;
      r.drain     = drain;
      request_q.push_back(r);
   endtask

   // Predict the response; LR updates the reservation.
   function automatic amo_result_type predict_amo(logic [31:0] insn, logic [63:0] addr,
                                                  logic [63:0] rs2v, logic [63:0] mdata);
      amo_result_type r;
      logic [4:0]  f5;
      logic [2:0]  f3;
      logic        word;
      logic        ok;
      logic        wr;
      logic [63:0] mem;
      logic [63:0] opnd;
      logic [63:0] wdata;
      logic [63:0] rdv;
      r  = '0;
      f5 = insn[31:27];
      f3 = insn[14:12];
      if (insn[6:0] != amou_pkg::OPC_AMO ||
          (f3 != amou_pkg::F3_WORD && f3 != amou_pkg::F3_DWORD)) return r;
      word  = (f3 == amou_pkg::F3_WORD);
      mem   = word ? {{32{mdata[31]}}, mdata[31:0]} : mdata;
      opnd  = (insn[24:20] != 5'd0) ? rs2v : 64'h0;
      if (word) opnd = {{32{opnd[31]}}, opnd[31:0]};
      ok    = 1'b1;
      wr    = 1'b1;
      wdata = 64'h0;
      rdv   = mem;
      case (f5)
         amou_pkg::F5_ADD:  wdata = mem + opnd;
         amou_pkg::F5_SWAP: wdata = opnd;
         amou_pkg::F5_XOR:  wdata = mem ^ opnd;
         amou_pkg::F5_OR:   wdata = mem | opnd;
         amou_pkg::F5_AND:  wdata = mem & opnd;
         amou_pkg::F5_MIN:  wdata = ($signed(mem) < $signed(opnd)) ? mem : opnd;
         amou_pkg::F5_MAX:  wdata = ($signed(opnd) < $signed(mem)) ? mem : opnd;
         amou_pkg::F5_MINU: wdata = (mem < opnd) ? mem : opnd;
         amou_pkg::F5_MAXU: wdata = (mem > opnd) ? mem : opnd;
         amou_pkg::F5_SC: begin
            if (reserved_addr == addr) begin
               wdata = opnd;
               rdv   = 64'h0;
            end else begin
               wr  = 1'b0;
               rdv = 64'h1;
            end
         end
         amou_pkg::F5_LR: begin
            wr = 1'b0;
            if (insn[24:20] == 5'd0) reserved_addr = addr;
            else ok = 1'b0;
         end
         default: ok = 1'b0;
      endcase
      if (!ok) return r;
      if (word) wdata[63:32] = 32'h0;
      if (!wr) wdata = 64'h0;
      r.handled   = 1'b1;
      r.mem_write = wr;
      r.mem_wdata = wdata;
      r.word_size = word;
      r.rd_write  = (insn[11:7] != 5'd0);
      r.rd_value  = (insn[11:7] != 5'd0) ? rdv : 64'h0;
      return r;
   endfunction

   task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   // Driver
   int  gap_left;
   bit  gap_served;
   always @(posedge clock) begin : driver
      amo_request_type head_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
         gap_served = 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (request_q.size() == 0) begin
            req_ch.valid <= 1'b0;
         end else if (request_q[0].drain &&
                      ((req_ch.valid && req_ch.ready) || accepted_cnt != rsp_cnt)) begin
            req_ch.valid <= 1'b0;
         end else if (request_q[0].gap != 0 && !gap_served) begin
            gap_left = request_q[0].gap - 1;
            gap_served = 1'b1;
            req_ch.valid <= 1'b0;
         end else begin
            head_req = request_q.pop_front();
            gap_served = 1'b0;
            req_ch.valid     <= 1'b1;
            req_ch.insn      <= head_req.insn;
            req_ch.rs1_value <= head_req.rs1_value;
            req_ch.rs2_value <= head_req.rs2_value;
            req_ch.mem_rdata <= head_req.mem_rdata;
         end
      end
   end

   // Response side back-pressure
   int hold_left;
   int stall_left;
   int sink_cyc;
   bit long_done;
   always @(posedge clock) begin : sink
      int r;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
         stall_left = 0;
         sink_cyc = 0;
         long_done = 1'b0;
      end else begin
         sink_cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!long_done && rsp_cnt >= 400) begin
            long_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (sink_cyc[8:7] == 2'b00) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               rsp_ch.ready <= 1'b1;
            end else begin
               stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
               rsp_ch.ready <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on request accept, check on response accept
   always @(posedge clock) begin : monitor
      amo_result_type want;
      if (reset) begin
         reserved_addr = 64'h0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            accepted_cnt++;
            result_q.push_back(predict_amo(req_ch.insn, req_ch.rs1_value, req_ch.rs2_value,
                                           req_ch.mem_rdata));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            rsp_cnt++;
            if (result_q.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected", $time);
            end else begin
               want = result_q.pop_front();
               compare_field("handled", 64'(want.handled), 64'(rsp_ch.handled));
               compare_field("mem_write", 64'(want.mem_write), 64'(rsp_ch.mem_write));
               compare_field("mem_wdata", want.mem_wdata, rsp_ch.mem_wdata);
               compare_field("word_size", 64'(want.word_size), 64'(rsp_ch.word_size));
               compare_field("rd_write", 64'(want.rd_write), 64'(rsp_ch.rd_write));
               compare_field("rd_value", want.rd_value, rsp_ch.rd_value);
            end
         end
      end
   end

   // Watchdog
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, idle_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [63:0] addr_pool [4];
      logic [63:0] addr;
      logic [63:0] addr_a;
      int          n;
      int          kind;
      int          block_left;
      int          next_drain;
      int          total;
      bit          calm;
      bit          drain;
      logic [2:0]  f3;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.insn = '0;
      req_ch.rs1_value = '0;
      req_ch.rs2_value = '0;
      req_ch.mem_rdata = '0;
      rsp_ch.ready = 1'b0;
      accepted_cnt = 0;
      rsp_cnt = 0;
      errors = 0;
      reserved_addr = 64'h0;

      // Directed: SC to address zero succeeds straight out of reset
      push_request(encode_amo(amou_pkg::F5_SC, amou_pkg::F3_DWORD, 5'd3, 5'd10, 5'd5),
                   64'h0, rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_SC, amou_pkg::F3_WORD, 5'd4, 5'd11, 5'd6),
                   64'h40, rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_ADD, amou_pkg::F3_DWORD, 5'd1, 5'd2, 5'd3),
                   rand64(), 64'h1, '1, pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_ADD, amou_pkg::F3_WORD, 5'd31, 5'd2, 5'd3),
                   rand64(), 64'h1, 64'hdead_beef_7fff_ffff, pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_SWAP, amou_pkg::F3_WORD, 5'd7, 5'd2, 5'd0),
                   rand64(), '1, rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_SWAP, amou_pkg::F3_DWORD, 5'd0, 5'd2, 5'd9),
                   rand64(), rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_XOR, amou_pkg::F3_DWORD, 5'd8, 5'd2, 5'd9),
                   rand64(), rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_OR, amou_pkg::F3_WORD, 5'd8, 5'd2, 5'd9),
                   rand64(), rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_AND, amou_pkg::F3_DWORD, 5'd8, 5'd2, 5'd9),
                   rand64(), rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_MIN, amou_pkg::F3_WORD, 5'd8, 5'd2, 5'd9),
                   rand64(), 64'h1, 64'h0000_0000_8000_0000, pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_MIN, amou_pkg::F3_DWORD, 5'd8, 5'd2, 5'd9),
                   rand64(), 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                   pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_MAX, amou_pkg::F3_DWORD, 5'd8, 5'd2, 5'd9),
                   rand64(), 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000,
                   pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_MAX, amou_pkg::F3_WORD, 5'd8, 5'd2, 5'd9),
                   rand64(), 64'h0000_0000_8000_0000, 64'hffff_ffff_7fff_ffff,
                   pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_MINU, amou_pkg::F3_WORD, 5'd8, 5'd2, 5'd9),
                   rand64(), 64'h1, 64'h0000_0000_ffff_ffff, pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_MAXU, amou_pkg::F3_DWORD, 5'd8, 5'd2, 5'd9),
                   rand64(), '1, 64'h0, pick_gap(0), 1'b0);
      // LR with rd x0 still reserves; SC succeeds twice since the reservation stays
      addr_a = rand64();
      push_request(encode_amo(amou_pkg::F5_LR, amou_pkg::F3_WORD, 5'd0, 5'd12, 5'd0),
                   addr_a, rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_SC, amou_pkg::F3_DWORD, 5'd0, 5'd12, 5'd13),
                   addr_a, rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_SC, amou_pkg::F3_WORD, 5'd14, 5'd12, 5'd13),
                   addr_a, rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_SC, amou_pkg::F3_DWORD, 5'd14, 5'd12, 5'd13),
                   addr_a ^ 64'h1, rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_LR, amou_pkg::F3_DWORD, 5'd15, 5'd12, 5'd1),
                   rand64(), rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_LR, amou_pkg::F3_DWORD, 5'd15, 5'd12, 5'd0),
                   rand64(), rand64(), 64'h8000_0000_0000_0001, pick_gap(0), 1'b0);
      push_request({encode_amo(amou_pkg::F5_ADD, amou_pkg::F3_DWORD, 5'd1, 5'd2, 5'd3)}
                   & ~32'h7f | OPC_OTHER,
                   rand64(), rand64(), rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(amou_pkg::F5_ADD, 3'd0, 5'd1, 5'd2, 5'd3), rand64(), rand64(),
                   rand64(), pick_gap(0), 1'b0);
      push_request(encode_amo(F5_UNUSED, amou_pkg::F3_WORD, 5'd1, 5'd2, 5'd3), rand64(),
                   rand64(), rand64(), pick_gap(0), 1'b0);
      push_request('1, '1, '1, '1, pick_gap(0), 1'b0);

      // Random: mostly well-formed AMOs and LR/SC pairs over a small address pool
      addr_pool[0] = rand64();
      addr_pool[1] = rand64();
      addr_pool[2] = 64'h0;
      addr_pool[3] = addr_pool[0] ^ (64'h1 << $urandom_range(0, 63));
      n = 0;
      block_left = 0;
      next_drain = DRAIN_SPACING / 2;
      calm = 1'b0;
      while (n < RANDOM_ITEMS) begin
         if (block_left <= 0) begin
            calm = ($urandom_range(0, 3) == 0);
            block_left = 40;
         end
         drain = (n >= next_drain);
         if (drain) next_drain += DRAIN_SPACING;
         kind = $urandom_range(0, 99);
         addr = ($urandom_range(0, 4) == 0) ? rand64() : addr_pool[$urandom_range(0, 3)];
         f3 = ($urandom_range(0, 1) != 0) ? amou_pkg::F3_WORD : amou_pkg::F3_DWORD;
         if (kind < 8) begin
            push_request($urandom, rand64(), rand64(), rand64(), pick_gap(calm), drain);
            n++;
         end else if (kind < 14) begin
            push_request(encode_amo(5'($urandom_range(0, 31)), 3'($urandom_range(0, 7)),
                                    pick_reg(), 5'($urandom), pick_reg()),
                         addr, pick_value(), pick_value(), pick_gap(calm), drain);
            n++;
         end else if (kind < 40) begin
            push_request(encode_amo(amou_pkg::F5_LR, f3, pick_reg(), 5'($urandom), 5'd0),
                         addr, rand64(), pick_value(), pick_gap(calm), drain);
            if ($urandom_range(0, 4) == 0) addr = addr_pool[$urandom_range(0, 3)];
            f3 = ($urandom_range(0, 1) != 0) ? amou_pkg::F3_WORD : amou_pkg::F3_DWORD;
            push_request(encode_amo(amou_pkg::F5_SC, f3, pick_reg(), 5'($urandom),
                                    pick_reg()),
                         addr, pick_value(), pick_value(), pick_gap(calm), 1'b0);
            n += 2;
         end else begin
            if ($urandom_range(0, 9) == 0) f3 = 3'($urandom_range(0, 7));
            push_request(encode_amo(pick_amo_op(), f3, pick_reg(), 5'($urandom), pick_reg()),
                         addr, pick_value(), pick_value(), pick_gap(calm), drain);
            n++;
         end
         block_left--;
      end
      total = request_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (accepted_cnt != total || rsp_cnt != accepted_cnt) @(posedge clock);
      repeat (8) @(posedge clock);
      if (result_q.size() != 0) begin
         errors++;
         $display("%0t: %0d expected responses never arrived", $time, result_q.size());
      end
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
